[hw/rtl/boxf3_pkg.sv]
// Shared types and constants of the 3x3 box filter with zero padding.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package boxf3_pkg;

    // Input beat command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Configuration register widths and reset values
    localparam int unsigned IMG_W_BITS = 11;
    localparam int unsigned IMG_H_BITS = 13;
    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET  = 11'd512;
    localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd512;

    // Neighborhood sum and divide-by-nine by reciprocal: floor(s * 7282 / 2^16)
    // equals floor(s / 9) for every sum up to 9 * 255.
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
    localparam int unsigned DIV9_SHIFT = 16;
    localparam int unsigned PROD_W     = SUM_W + RECIP_W;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;

    // Input beat
    typedef struct packed {
        logic       command;
        logic [7:0] pixel_value;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [7:0] mean_value;
        logic       last_of_image;
    } t_out_beat;

    // One classified column of work: new window column plus output masks
    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] pix;
        logic       emit;
        logic       top_en;
        logic       bot_en;
        logic       left_en;
        logic       right_en;
        logic       last;
    } t_work;

endpackage

[hw/rtl/boxf3_front.sv]
// Front part of the box filter: configuration registers, position counters,
// beat classification and the two line stores. Uses boxf3_pkg.
module boxf3_front #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [boxf3_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [boxf3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    input  boxf3_pkg::t_in_beat                  i_in_data,
    output logic                                 o_in_stall,
    input  logic [boxf3_pkg::QUEUE_CNT_W-1:0]    i_queue_count,
    output logic                                 o_push,
    output boxf3_pkg::t_work                     o_push_item
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

    logic [boxf3_pkg::IMG_W_BITS-1:0] r_img_w;
    logic [boxf3_pkg::IMG_H_BITS-1:0] r_img_h;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;

    logic accept, drain, ignore, proc, emit, last;
    logic in_col_last, out_col_last;
    logic top_en, bot_en, left_en, right_en;
    logic [7:0] pix;
    boxf3_pkg::t_work a_item;

    logic r_a_valid;
    boxf3_pkg::t_work r_a;
    logic [CW-1:0] r_a_col;
    logic [7:0] r_rd_top, r_rd_mid;
    logic r_fwd;
    logic [7:0] r_fwd_val;

    logic [7:0] mid_mem [MAX_WIDTH];
    logic [7:0] top_mem [MAX_WIDTH];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= boxf3_pkg::IMAGE_WIDTH_RESET;
            r_img_h <= boxf3_pkg::IMAGE_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                boxf3_pkg::REG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data[boxf3_pkg::IMG_W_BITS-1:0];
                end
                boxf3_pkg::REG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data[boxf3_pkg::IMG_H_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the dimensions: zero reads as one, large values saturate
    always_comb begin
        if (r_img_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_img_w) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_img_h) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_img_h);
        end
    end

    // Hold off input while the queue could not take everything in flight
    assign o_in_stall = !((i_queue_count + boxf3_pkg::QUEUE_CNT_W'(r_a_valid))
                          < boxf3_pkg::QUEUE_CNT_W'(boxf3_pkg::QUEUE_DEPTH));

    // Classify the beat: drop early flushes, zero pixels during the drain
    assign accept = i_in_valid && !o_in_stall;
    assign drain  = r_in_row >= h_eff;
    assign ignore = !drain && (i_in_data.command == boxf3_pkg::CMD_FLUSH);
    assign proc   = accept && !ignore;
    assign pix    = drain ? 8'd0 : i_in_data.pixel_value;

    // An output is due once one row plus one pixel has gone in
    assign emit = (r_in_row != '0) && !((r_in_row == RW'(1)) && (r_in_col == '0));

    assign in_col_last  = (WW'(r_in_col) + WW'(1)) >= w_eff;
    assign out_col_last = (WW'(r_out_col) + WW'(1)) >= w_eff;
    assign top_en   = r_out_row != '0;
    assign bot_en   = (r_out_row + RW'(1)) < h_eff;
    assign left_en  = r_out_col != '0;
    assign right_en = !out_col_last;
    assign last     = emit && !bot_en && out_col_last;

    // Advance positions; restart on the final output or a register write
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (proc) begin
            if (in_col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (out_col_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + RW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
        if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_a_valid <= proc;
        end
    end

    // Build the work item; line store data joins it in the next cycle
    always_comb begin
        a_item          = '0;
        a_item.pix      = pix;
        a_item.emit     = emit;
        a_item.top_en   = top_en;
        a_item.bot_en   = bot_en;
        a_item.left_en  = left_en;
        a_item.right_en = right_en;
        a_item.last     = last;
    end

    // Capture the item and a forward for back-to-back hits on one column
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_a     <= a_item;
            r_a_col <= r_in_col;
        end
        r_fwd     <= r_a_valid && (r_a_col == r_in_col);
        r_fwd_val <= r_rd_mid;
    end

    // Previous-row store: read old value, write the new pixel
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_rd_mid           <= mid_mem[r_in_col];
            mid_mem[r_in_col]  <= pix;
        end
    end

    // Row-before store: takes the registered previous-row value in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_rd_top <= top_mem[r_in_col];
        end
        if (r_a_valid) begin
            top_mem[r_a_col] <= r_rd_mid;
        end
    end

    // Hand the completed column to the queue
    assign o_push = r_a_valid;
    always_comb begin
        o_push_item     = r_a;
        o_push_item.top = r_fwd ? r_fwd_val : r_rd_top;
        o_push_item.mid = r_rd_mid;
    end

endmodule

[hw/rtl/boxf3_queue.sv]
// Short FIFO of work items between the front and back parts of the box filter.
// Uses boxf3_pkg for the item type and depth.
module boxf3_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  boxf3_pkg::t_work                     i_push_item,
    input  logic                                 i_pop,
    output boxf3_pkg::t_work                     o_head,
    output logic                                 o_empty,
    output logic [boxf3_pkg::QUEUE_CNT_W-1:0]    o_count
);

    boxf3_pkg::t_work r_mem [boxf3_pkg::QUEUE_DEPTH];
    logic [boxf3_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [boxf3_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [boxf3_pkg::QUEUE_CNT_W-1:0] r_count;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + boxf3_pkg::QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + boxf3_pkg::QUEUE_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + boxf3_pkg::QUEUE_CNT_W'(1);
                2'b01:   r_count <= r_count - boxf3_pkg::QUEUE_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

endmodule

[hw/rtl/boxf3_back.sv]
// Back part of the box filter: 3x3 window, masked sum, divide by nine and
// the output register. Uses boxf3_pkg.
module boxf3_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  boxf3_pkg::t_work      i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output boxf3_pkg::t_out_beat  o_out_data,
    input  logic                  i_out_stall
);

    logic [7:0] r_win [9];
    logic [7:0] n_win [9];

    logic en;
    logic r_b_valid;
    boxf3_pkg::t_work r_b;
    logic r_c_valid;
    logic [boxf3_pkg::SUM_W-1:0] r_c_sum;
    logic r_c_last;
    logic r_out_valid;
    boxf3_pkg::t_out_beat r_out;

    logic [boxf3_pkg::SUM_W-1:0] sum;
    logic [2:0] row_en, col_en;
    logic [boxf3_pkg::PROD_W-1:0] prod;

    // Whole back pipeline moves when the output beat is free or taken
    assign en    = !r_out_valid || !i_out_stall;
    assign o_pop = en && !i_empty;

    // Window: clear once the final output is summed, then shift in the new column; a register write clears it
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_win[k] = (r_b_valid && r_b.last) ? 8'd0 : r_win[k];
        end
        if (o_pop) begin
            for (int i = 0; i < 3; i++) begin
                n_win[i*3]   = n_win[i*3+1];
                n_win[i*3+1] = n_win[i*3+2];
            end
            n_win[2] = i_head.top;
            n_win[5] = i_head.mid;
            n_win[8] = i_head.pix;
        end
        if (i_clear) begin
            for (int k = 0; k < 9; k++) begin
                n_win[k] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= 8'd0;
            end
        end else if (en || i_clear) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // Sum the neighbors that lie inside the image
    assign row_en = {r_b.bot_en, 1'b1, r_b.top_en};
    assign col_en = {r_b.right_en, 1'b1, r_b.left_en};
    always_comb begin
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_en[i] && col_en[j]) begin
                    sum = sum + boxf3_pkg::SUM_W'(r_win[i*3+j]);
                end
            end
        end
    end

    // Divide by nine through the reciprocal
    assign prod = boxf3_pkg::PROD_W'(r_c_sum) * boxf3_pkg::PROD_W'(boxf3_pkg::DIV9_RECIP);

    // Valid bits of the back stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b_valid   <= o_pop && i_head.emit;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b                 <= i_head;
            r_c_sum             <= sum;
            r_c_last            <= r_b.last;
            r_out.mean_value    <= prod[boxf3_pkg::DIV9_SHIFT+7:boxf3_pkg::DIV9_SHIFT];
            r_out.last_of_image <= r_c_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/box_filter_3x3_zero_pad_unit.sv]
// 3x3 mean filter with zero padding over a raster-order grayscale stream.
// Depends on boxf3_pkg, boxf3_front, boxf3_queue and boxf3_back.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one beat is a pixel or
// a flush tick. Pixels arrive in raster order; the result for a pixel is due
// once one row plus one pixel more has been accepted. After the last pixel of
// an image, send flush ticks (width + 1 of them) to drain the pending results;
// flushes that arrive while pixels are still expected are dropped.
// Output channel (o_out_valid / i_out_stall / o_out_data): floor(sum / 9) of
// each pixel's neighborhood; last_of_image marks the image's final result.
// Configuration: i_cfg_we writes image_width (index 0) or image_height
// (index 1) and restarts the image; write only while the block is idle.
// Throughput: one beat per cycle unless the input stalls, set by the
// single-port line store reads and the one-column window shift. A result
// passes the line store read, queue, window, sum and divide stages.
// When the receiver stalls, the back pipeline holds and the 4-entry queue
// fills; the input then stalls. Reset clears positions, window and the
// queue; the line stores need no clearing.
module box_filter_3x3_zero_pad_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [boxf3_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [boxf3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    input  boxf3_pkg::t_in_beat                  i_in_data,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output boxf3_pkg::t_out_beat                 o_out_data,
    input  logic                                 i_out_stall
);

    logic                              push;
    boxf3_pkg::t_work                  push_item;
    logic                              pop;
    boxf3_pkg::t_work                  head;
    logic                              empty;
    logic [boxf3_pkg::QUEUE_CNT_W-1:0] count;

    // Classify beats and read line stores
    boxf3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .i_queue_count (count),
        .o_push        (push),
        .o_push_item   (push_item)
    );

    // Decouple front from back
    boxf3_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty),
        .o_count     (count)
    );

    // Window, sum, divide and output beat
    boxf3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
